>>> hw/rtl/tnp_pkg.sv
// ----------------------------------------------------------------------------
// tnp_pkg
// Shared constants, register indexes and controller/datapath handshake types
// for the two nearest point finder.
// ----------------------------------------------------------------------------
package tnp_pkg;

   localparam int COORD_BITS_DEF = 20;
   localparam int INDEX_BITS_DEF = 16;
   localparam int AXES           = 3;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIGIN_Z = 2'd2;

   typedef struct packed {
      logic load_point;
      logic square;
      logic update;
      logic root_go;
      logic root_sel_runner;
      logic store_best_root;
      logic store_runner_root;
      logic emit;
   } tnp_cmd_type;

   typedef struct packed {
      logic point_last;
      logic root_done;
      logic out_free;
   } tnp_status_type;

endpackage

>>> hw/rtl/tnp_if.sv
// ----------------------------------------------------------------------------
// tnp_req_if / tnp_rsp_if
// Valid/ready channels for point requests and search results.
// ----------------------------------------------------------------------------
interface tnp_req_if #(
   parameter int COORD_BITS = tnp_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS = tnp_pkg::INDEX_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;
   logic        [INDEX_BITS-1:0] point_index;
   logic                         present;
   logic                         last_item;

   modport source (output valid, point_x, point_y, point_z, point_index, present, last_item,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, point_index, present, last_item,
                 output ready);
endinterface

interface tnp_rsp_if #(
   parameter int COORD_BITS = tnp_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS = tnp_pkg::INDEX_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  nearest_found;
   logic [INDEX_BITS-1:0] nearest_index;
   logic [COORD_BITS:0]   nearest_distance;
   logic                  second_found;
   logic [INDEX_BITS-1:0] second_index;
   logic [COORD_BITS:0]   second_distance;

   modport source (output valid, nearest_found, nearest_index, nearest_distance,
                   second_found, second_index, second_distance,
                   input ready);
   modport sink (input valid, nearest_found, nearest_index, nearest_distance,
                 second_found, second_index, second_distance,
                 output ready);
endinterface

>>> hw/rtl/tnp_isqrt.sv
// ----------------------------------------------------------------------------
// tnp_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tnp_isqrt #(
   parameter int ROOT_BITS = tnp_pkg::COORD_BITS_DEF + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2*ROOT_BITS-1:0] operand,
   output logic                   done,
   output logic [ROOT_BITS-1:0]   root
);

   localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

   logic [2*ROOT_BITS-1:0] val_ff, val_in;
   logic [ROOT_BITS+1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [ROOT_BITS+1:0]   rem_shift;
   logic [ROOT_BITS+1:0]   trial;

   always_comb begin
      rem_shift = {rem_ff[ROOT_BITS-1:0], val_ff[2*ROOT_BITS-1 -: 2]};
      trial     = {root_ff, 2'b01};
      val_in    = val_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         val_in  = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_BITS'(ROOT_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[2*ROOT_BITS-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> hw/rtl/tnp_datapath.sv
// ----------------------------------------------------------------------------
// tnp_datapath
// Origin registers, axis distances, nearest/second search state, root unit
// and the result register.
// ----------------------------------------------------------------------------
module tnp_datapath #(
   parameter int COORD_BITS = tnp_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS = tnp_pkg::INDEX_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [tnp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [COORD_BITS-1:0]               csr_write_data,
   input  logic signed [COORD_BITS-1:0]        point_x,
   input  logic signed [COORD_BITS-1:0]        point_y,
   input  logic signed [COORD_BITS-1:0]        point_z,
   input  logic [INDEX_BITS-1:0]               point_index,
   input  logic                                present,
   input  logic                                last_item,
   input  tnp_pkg::tnp_cmd_type                cmd,
   output tnp_pkg::tnp_status_type             status,
   tnp_rsp_if.source                           rsp_ch
);

   localparam int SQ_BITS   = 2 * COORD_BITS + 2;
   localparam int DIST_BITS = COORD_BITS + 1;

   logic [COORD_BITS-1:0]   origin_ff [tnp_pkg::AXES];
   logic [COORD_BITS-1:0]   coord     [tnp_pkg::AXES];
   logic [COORD_BITS:0]     diff      [tnp_pkg::AXES];
   logic [COORD_BITS:0]     neg       [tnp_pkg::AXES];
   logic [COORD_BITS-1:0]   abs_in    [tnp_pkg::AXES];
   logic [COORD_BITS-1:0]   abs_ff    [tnp_pkg::AXES];
   logic [2*COORD_BITS-1:0] sq_ff     [tnp_pkg::AXES];

   logic                  present_ff;
   logic                  last_ff;
   logic [INDEX_BITS-1:0] index_ff;

   logic [SQ_BITS-1:0]    dist_sq;
   logic [SQ_BITS-1:0]    best_sq_ff;
   logic [INDEX_BITS-1:0] best_idx_ff;
   logic                  best_valid_ff;
   logic [SQ_BITS-1:0]    runner_sq_ff;
   logic [INDEX_BITS-1:0] runner_idx_ff;
   logic                  runner_valid_ff;

   logic [DIST_BITS-1:0]  best_root_ff;
   logic [DIST_BITS-1:0]  runner_root_ff;
   logic [DIST_BITS-1:0]  root;
   logic                  root_done;

   logic                  rsp_valid_ff;
   logic                  out_found_ff, out_second_ff;
   logic [INDEX_BITS-1:0] out_idx_ff, out_second_idx_ff;
   logic [DIST_BITS-1:0]  out_dist_ff, out_second_dist_ff;

   // origin registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < tnp_pkg::AXES; a++) begin
            origin_ff[a] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            tnp_pkg::CSR_ORIGIN_X: origin_ff[0] <= csr_write_data;
            tnp_pkg::CSR_ORIGIN_Y: origin_ff[1] <= csr_write_data;
            tnp_pkg::CSR_ORIGIN_Z: origin_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // absolute axis differences
   always_comb begin
      coord[0] = point_x;
      coord[1] = point_y;
      coord[2] = point_z;
      for (int a = 0; a < tnp_pkg::AXES; a++) begin
         diff[a]   = {coord[a][COORD_BITS-1], coord[a]}
                   - {origin_ff[a][COORD_BITS-1], origin_ff[a]};
         neg[a]    = -diff[a];
         abs_in[a] = diff[a][COORD_BITS] ? neg[a][COORD_BITS-1:0] : diff[a][COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         abs_ff     <= abs_in;
         present_ff <= present;
         last_ff    <= last_item;
         index_ff   <= point_index;
      end
      if (cmd.square) begin
         for (int a = 0; a < tnp_pkg::AXES; a++) begin
            sq_ff[a] <= abs_ff[a] * abs_ff[a];
         end
      end
   end

   assign dist_sq = SQ_BITS'(sq_ff[0]) + SQ_BITS'(sq_ff[1]) + SQ_BITS'(sq_ff[2]);

   // nearest and second search state
   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff   <= 1'b0;
         runner_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         best_valid_ff   <= 1'b0;
         runner_valid_ff <= 1'b0;
      end else if (cmd.update && present_ff) begin
         if (!best_valid_ff || dist_sq < best_sq_ff) begin
            runner_sq_ff    <= best_sq_ff;
            runner_idx_ff   <= best_idx_ff;
            runner_valid_ff <= best_valid_ff;
            best_sq_ff      <= dist_sq;
            best_idx_ff     <= index_ff;
            best_valid_ff   <= 1'b1;
         end else if (!runner_valid_ff || dist_sq < runner_sq_ff) begin
            runner_sq_ff    <= dist_sq;
            runner_idx_ff   <= index_ff;
            runner_valid_ff <= 1'b1;
         end
      end
   end

   tnp_isqrt #(
      .ROOT_BITS (DIST_BITS)
   ) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.root_go),
      .operand (cmd.root_sel_runner ? runner_sq_ff : best_sq_ff),
      .done    (root_done),
      .root    (root)
   );

   always_ff @(posedge clock) begin
      if (cmd.store_best_root) begin
         best_root_ff <= root;
      end
      if (cmd.store_runner_root) begin
         runner_root_ff <= root;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_found_ff       <= best_valid_ff;
         out_idx_ff         <= best_valid_ff ? best_idx_ff : '0;
         out_dist_ff        <= best_valid_ff ? best_root_ff : '0;
         out_second_ff      <= runner_valid_ff;
         out_second_idx_ff  <= runner_valid_ff ? runner_idx_ff : '0;
         out_second_dist_ff <= runner_valid_ff ? runner_root_ff : '0;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.nearest_found    = out_found_ff;
   assign rsp_ch.nearest_index    = out_idx_ff;
   assign rsp_ch.nearest_distance = out_dist_ff;
   assign rsp_ch.second_found     = out_second_ff;
   assign rsp_ch.second_index     = out_second_idx_ff;
   assign rsp_ch.second_distance  = out_second_dist_ff;

   assign status.point_last = last_ff;
   assign status.root_done  = root_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ch.ready;

endmodule

>>> hw/rtl/tnp_ctrl.sv
// ----------------------------------------------------------------------------
// tnp_ctrl
// Sequencer: point intake, squaring, search update, root passes and result
// hand-off.
// ----------------------------------------------------------------------------
module tnp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tnp_pkg::tnp_status_type status,
   output tnp_pkg::tnp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_UPDATE,
      S_ROOT_BEST,
      S_WAIT_BEST,
      S_ROOT_RUNNER,
      S_WAIT_RUNNER,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:        if (req_valid) state_in = S_SQUARE;
         S_SQUARE:      state_in = S_UPDATE;
         S_UPDATE:      state_in = status.point_last ? S_ROOT_BEST : S_IDLE;
         S_ROOT_BEST:   state_in = S_WAIT_BEST;
         S_WAIT_BEST:   if (status.root_done) state_in = S_ROOT_RUNNER;
         S_ROOT_RUNNER: state_in = S_WAIT_RUNNER;
         S_WAIT_RUNNER: if (status.root_done) state_in = S_EMIT;
         S_EMIT:        if (status.out_free) state_in = S_IDLE;
         default:       state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd                   = '0;
      cmd.load_point        = (state_ff == S_IDLE) && req_valid;
      cmd.square            = (state_ff == S_SQUARE);
      cmd.update            = (state_ff == S_UPDATE);
      cmd.root_go           = (state_ff == S_ROOT_BEST) || (state_ff == S_ROOT_RUNNER);
      cmd.root_sel_runner   = (state_ff == S_ROOT_RUNNER);
      cmd.store_best_root   = (state_ff == S_WAIT_BEST) && status.root_done;
      cmd.store_runner_root = (state_ff == S_WAIT_RUNNER) && status.root_done;
      cmd.emit              = (state_ff == S_EMIT) && status.out_free;
   end

endmodule

>>> hw/rtl/two_nearest_point_finder_top.sv
// ----------------------------------------------------------------------------
// two_nearest_point_finder_top
// Each request passes through intake, square and compare/update; a new request
// is taken only once the previous one is through. A last request adds two root
// passes of the shared one-bit-per-cycle square root unit before the result.
// Reset (synchronous, active high) clears origins to 0 and empties the search.
// ----------------------------------------------------------------------------
module two_nearest_point_finder_top #(
   parameter int COORD_BITS = tnp_pkg::COORD_BITS_DEF,
   parameter int INDEX_BITS = tnp_pkg::INDEX_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   tnp_req_if.sink                            req_ch,
   tnp_rsp_if.source                          rsp_ch,
   input  logic                               csr_write_enable,
   input  logic [tnp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]              csr_write_data
);

   tnp_pkg::tnp_cmd_type    cmd;
   tnp_pkg::tnp_status_type status;
   logic                    req_ready;

   tnp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   tnp_datapath #(
      .COORD_BITS (COORD_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .point_x          (req_ch.point_x),
      .point_y          (req_ch.point_y),
      .point_z          (req_ch.point_z),
      .point_index      (req_ch.point_index),
      .present          (req_ch.present),
      .last_item        (req_ch.last_item),
      .cmd              (cmd),
      .status           (status),
      .rsp_ch           (rsp_ch)
   );

endmodule
